### rtl/cfr_pkg.sv
`timescale 1ns / 1ps

package cfr_pkg;

   localparam int unsigned HeaderBytes = 4;

   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_END  = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [6:0]  frame_length;
      logic        address_match;
      logic        checksum_ok;
      logic        command_valid;
      logic [7:0]  command_code;
      logic [15:0] command_data;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_item_type;

endpackage

### rtl/cfr_input_stage.sv
`timescale 1ns / 1ps

module cfr_input_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cfr_pkg::req_item_type req_item,
   input  logic                  advance,
   output cfr_pkg::stage_item_type stage
);
   import cfr_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   assign load      = !valid_ff || advance;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         item_ff <= req_item;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

### rtl/cfr_frame_check.sv
`timescale 1ns / 1ps

module cfr_frame_check #(
   parameter int unsigned RX_BUFFER_BYTES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfr_pkg::stage_item_type stage,
   output logic                    advance,
   input  logic [7:0]              node_address,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output cfr_pkg::rsp_item_type   rsp_item
);
   import cfr_pkg::*;

   localparam int unsigned CountWidth = $clog2(RX_BUFFER_BYTES + 1);

   logic [CountWidth-1:0] count_ff, count_in;
   logic [15:0]           sum_ff, sum_in;
   logic [7:0]            older_ff, older_in;
   logic [7:0]            newer_ff, newer_in;
   logic [7:0]            header_ff [HeaderBytes];
   logic                  out_valid_ff, out_valid_in;
   rsp_item_type          out_item_ff;
   rsp_item_type          result;
   logic                  is_end;
   logic                  store_byte;
   logic                  out_free;
   logic [15:0]           earlier_sum;
   logic                  addr_ok;
   logic                  sum_ok;
   logic                  cmd_ok;

   assign is_end     = (stage.item.req_type == KIND_END);
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign advance    = stage.valid && (!is_end || out_free);
   assign store_byte = advance && !is_end && (count_ff < CountWidth'(RX_BUFFER_BYTES));

   assign earlier_sum = sum_ff - {8'd0, older_ff} - {8'd0, newer_ff};
   assign addr_ok     = (header_ff[0] == node_address);
   assign sum_ok      = (count_ff > CountWidth'(2)) && (earlier_sum == {older_ff, newer_ff});
   assign cmd_ok      = addr_ok && sum_ok;

   always_comb begin
      result.frame_length  = 7'(count_ff);
      result.address_match = addr_ok;
      result.checksum_ok   = sum_ok;
      result.command_valid = cmd_ok;
      result.command_code  = cmd_ok ? header_ff[1] : 8'd0;
      result.command_data  = cmd_ok ? {header_ff[2], header_ff[3]} : 16'd0;
   end

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      older_in = older_ff;
      newer_in = newer_ff;
      if (advance && is_end) begin
         count_in = '0;
         sum_in   = 16'd0;
         older_in = 8'd0;
         newer_in = 8'd0;
      end else if (store_byte) begin
         count_in = count_ff + CountWidth'(1);
         sum_in   = sum_ff + {8'd0, stage.item.rx_byte};
         older_in = newer_ff;
         newer_in = stage.item.rx_byte;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && is_end) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= 16'd0;
         older_ff     <= 8'd0;
         newer_ff     <= 8'd0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < HeaderBytes; i++) begin
            header_ff[i] <= 8'd0;
         end
      end else begin
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         older_ff     <= older_in;
         newer_ff     <= newer_in;
         out_valid_ff <= out_valid_in;
         if (store_byte && (count_ff < CountWidth'(HeaderBytes))) begin
            header_ff[count_ff[1:0]] <= stage.item.rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_end) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

### rtl/command_frame_receiver.sv
`timescale 1ns / 1ps
// An end-of-frame item is registered in the input stage and then in the result register.
// Throughput: one item per cycle while req_stall stays low; the input register and the result register
// let a new item enter while a finished result still waits to be taken.
// Reset is synchronous and active high; it clears the node address, the stored
// header bytes, the byte count, the running sum and both pipeline valid flags.
module command_frame_receiver #(
   parameter int unsigned RX_BUFFER_BYTES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cfr_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cfr_pkg::rsp_item_type rsp_item,
   input  logic                  csr_write_enable,
   input  logic [7:0]            csr_write_data
);
   import cfr_pkg::*;

   logic [7:0]     node_address_ff;
   stage_item_type stage;
   logic           advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_address_ff <= 8'd0;
      end else if (csr_write_enable) begin
         node_address_ff <= csr_write_data;
      end
   end

   cfr_input_stage u_input_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .advance   (advance),
      .stage     (stage)
   );

   cfr_frame_check #(
      .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
   ) u_frame_check (
      .clock        (clock),
      .reset        (reset),
      .stage        (stage),
      .advance      (advance),
      .node_address (node_address_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_item     (rsp_item)
   );

endmodule

### bench/command_frame_checker.sv
`timescale 1ns / 1ps

module command_frame_checker #(
   parameter int unsigned RX_BUFFER_BYTES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  cfr_pkg::req_item_type req_item,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  cfr_pkg::rsp_item_type rsp_item,
   input  logic                  csr_write_enable,
   input  logic [7:0]            csr_write_data,
   output int                    mismatch_count,
   output int                    reports_pending
);
   import cfr_pkg::*;

   logic [7:0]   node_address;
   logic [7:0]   header_bytes [HeaderBytes];
   int unsigned  stored_count;
   logic [15:0]  frame_sum;
   logic [7:0]   older_tail;
   logic [7:0]   newer_tail;
   rsp_item_type expected_reports [$];
   int           mismatch_total = 0;

   task automatic clear_frame();
      stored_count = 0;
      frame_sum    = '0;
      older_tail   = '0;
      newer_tail   = '0;
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatch_total++;
      end
   endtask

   task automatic advance_frame(input req_item_type item);
      rsp_item_type report;
      logic [15:0]  earlier;
      if (item.req_type == KIND_BYTE) begin
         if (stored_count < RX_BUFFER_BYTES) begin
            if (stored_count < HeaderBytes) begin
               header_bytes[stored_count] = item.rx_byte;
            end
            frame_sum    = frame_sum + 16'(item.rx_byte);
            older_tail   = newer_tail;
            newer_tail   = item.rx_byte;
            stored_count = stored_count + 1;
         end
      end else begin
         earlier = frame_sum - 16'(older_tail) - 16'(newer_tail);
         report = '0;
         report.frame_length  = 7'(stored_count);
         report.address_match = (header_bytes[0] == node_address);
         report.checksum_ok   = (stored_count > 2) && (earlier == {older_tail, newer_tail});
         report.command_valid = report.address_match && report.checksum_ok;
         if (report.command_valid) begin
            report.command_code = header_bytes[1];
            report.command_data = {header_bytes[2], header_bytes[3]};
         end
         expected_reports.push_back(report);
         clear_frame();
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         node_address = '0;
         for (int i = 0; i < HeaderBytes; i++) begin
            header_bytes[i] = '0;
         end
         clear_frame();
         expected_reports.delete();
      end else begin
         if (csr_write_enable) begin
            node_address = csr_write_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected report: frame_length expected none actual %0d",
                      rsp_item.frame_length);
               mismatch_total++;
            end else begin
               want = expected_reports.pop_front();
               compare_field("frame_length", want.frame_length, rsp_item.frame_length);
               compare_field("address_match", want.address_match, rsp_item.address_match);
               compare_field("checksum_ok", want.checksum_ok, rsp_item.checksum_ok);
               compare_field("command_valid", want.command_valid, rsp_item.command_valid);
               compare_field("command_code", want.command_code, rsp_item.command_code);
               compare_field("command_data", want.command_data, rsp_item.command_data);
            end
         end
         if (req_valid && !req_stall) begin
            advance_frame(req_item);
         end
      end
      reports_pending <= expected_reports.size();
      mismatch_count  <= mismatch_total;
   end

endmodule

### bench/tb_command_frame_receiver.sv
`timescale 1ns / 1ps

module tb_command_frame_receiver;
   import cfr_pkg::*;

   localparam int unsigned BufferBytes   = 64;
   localparam int unsigned ItemsPerPhase = 135;

   logic         clock            = 1'b0;
   logic         reset            = 1'b1;
   logic         req_valid        = 1'b0;
   req_item_type req_item         = '0;
   logic         rsp_stall        = 1'b0;
   logic         csr_write_enable = 1'b0;
   logic [7:0]   csr_write_data   = '0;
   logic         req_stall;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   int           mismatch_count;
   int           reports_pending;

   int           sender_idle_pct    = 0;
   int           receiver_stall_pct = 0;
   int           items_sent         = 0;
   logic [7:0]   node_address       = '0;
   logic [7:0]   frame_bytes [$];

   command_frame_receiver #(
      .RX_BUFFER_BYTES(BufferBytes)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item        (rsp_item),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   command_frame_checker #(
      .RX_BUFFER_BYTES(BufferBytes)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item        (rsp_item),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .mismatch_count  (mismatch_count),
      .reports_pending (reports_pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic send_item(input req_kind_type kind, input logic [7:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{req_type: kind, rx_byte: value};
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) begin
         send_item(KIND_BYTE, frame_bytes[i]);
      end
      send_item(KIND_END, 8'($urandom_range(255)));
   endtask

   task automatic append_checksum();
      logic [15:0] total = '0;
      foreach (frame_bytes[i]) begin
         total = total + 16'(frame_bytes[i]);
      end
      frame_bytes.push_back(total[15:8]);
      frame_bytes.push_back(total[7:0]);
   endtask

   task automatic wait_for_reports();
      req_valid <= 1'b0;
      do @(posedge clock); while (reports_pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_node_address(input logic [7:0] value);
      wait_for_reports();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      node_address      = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Most frames are well formed with random content; the rest carry a bad
   // checksum, are too short to hold one, or are plain noise of up to BufferBytes + 16 bytes.
   task automatic build_random_frame();
      int pick;
      int shape;
      int body_len;
      pick = $urandom_range(99);
      frame_bytes.delete();
      if (pick < 70) begin
         shape = $urandom_range(99);
         if (shape < 75) begin
            body_len = $urandom_range(6, 1);
         end else if (shape < 93) begin
            body_len = $urandom_range(BufferBytes - 2, 7);
         end else begin
            body_len = BufferBytes - 2;
         end
         frame_bytes.push_back(($urandom_range(99) < 85) ? node_address
                                                         : 8'($urandom_range(255)));
         repeat (body_len - 1) frame_bytes.push_back(8'($urandom_range(255)));
         append_checksum();
         if (shape >= 93) begin
            repeat ($urandom_range(8, 1)) frame_bytes.push_back(8'($urandom_range(255)));
         end
      end else if (pick < 82) begin
         frame_bytes.push_back(node_address);
         repeat ($urandom_range(9)) frame_bytes.push_back(8'($urandom_range(255)));
         append_checksum();
         frame_bytes[frame_bytes.size() - 1 - $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
      end else if (pick < 92) begin
         repeat ($urandom_range(2)) frame_bytes.push_back(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(BufferBytes + 16)) begin
            frame_bytes.push_back(8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      logic [7:0] address_choice;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      write_node_address(8'hA5);

      // An end of frame with nothing stored compares the header left by reset.
      frame_bytes.delete();
      send_frame();
      frame_bytes = '{8'hA5, 8'hFF, 8'h00, 8'hFF, 8'h80};
      append_checksum();
      send_frame();
      // A one-byte frame replaces only the first header byte and reuses the rest from the frame before it.
      frame_bytes = '{8'hA5};
      send_frame();
      frame_bytes = '{8'h00, 8'h7F};
      send_frame();
      frame_bytes = '{8'hA5, 8'h01, 8'h02, 8'h03};
      append_checksum();
      frame_bytes[frame_bytes.size() - 1] ^= 8'h01;
      send_frame();
      // The shortest frame that can pass: the address and its checksum.
      frame_bytes = '{8'hA5};
      append_checksum();
      send_frame();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               address_choice = 8'h00;
            end
            1: begin
               address_choice = 8'hFF;
            end
            2: begin
               address_choice = 8'h01;
            end
            3: begin
               address_choice = 8'h80;
            end
            default: begin
               address_choice = 8'($urandom_range(255));
            end
         endcase
         write_node_address(address_choice);
         case (phase % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 62;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 62;
            end
            default: begin
               sender_idle_pct    = 9;
               receiver_stall_pct = 9;
            end
         endcase
         items_sent = 0;
         while (items_sent < ItemsPerPhase) begin
            build_random_frame();
            send_frame();
         end
      end

      wait_for_reports();
      if (mismatch_count == 0) begin
         $display("PASS command_frame_receiver");
      end else begin
         $display("FAIL command_frame_receiver");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL command_frame_receiver");
      $finish;
   end

endmodule

### filelist.f
rtl/cfr_pkg.sv
rtl/cfr_input_stage.sv
rtl/cfr_frame_check.sv
rtl/command_frame_receiver.sv
bench/command_frame_checker.sv
bench/tb_command_frame_receiver.sv
